// ----- hw/rtl/mgs_pkg.sv -----
// Shared constants and types for the insertion-cell integer sorter.
`timescale 1ns / 1ps
package mgs_pkg;

    localparam int SIZE   = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(SIZE + 1);

    typedef logic signed [DATA_W-1:0] t_value;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;   // place the incoming sample into the ordered row
        logic shift;    // move every entry one cell towards the head
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/mgs_cell.sv -----
// One cell of the ordered row: holds a value and trades it with its neighbours.
`timescale 1ns / 1ps
module mgs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mgs_pkg::t_cell_ctrl i_ctrl,
    input  mgs_pkg::t_value    i_sample,
    input  mgs_pkg::t_value    i_left_value,
    input  logic               i_left_valid,
    input  logic               i_left_gt,
    input  mgs_pkg::t_value    i_right_value,
    input  logic               i_right_valid,
    output mgs_pkg::t_value    o_value,
    output logic               o_valid,
    output logic               o_gt
);
    import mgs_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   r_valid;
    logic   n_valid;

    // sample belongs at or before this cell; an empty cell counts as +infinity
    assign o_gt    = !r_valid || (i_sample < r_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.insert && o_gt) begin
            if (!i_left_gt) begin
                n_value = i_sample;
                n_valid = 1'b1;
            end else begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- hw/rtl/merge_sort_integers.sv -----
// Top level of the integer sorter: a row of insertion cells and its fill/drain control.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one signed 32-bit sample
//   per item plus i_is_final, which closes the set. The SIZE-th sample of a
//   set closes it as well, whatever its i_is_final bit.
//   Output channel (o_out_valid / i_out_ready) returns the set in ascending
//   signed order, duplicates kept; o_final_out marks the largest, last item.
//   Fill: each sample slots into the ordered cell row in the cycle it is
//   accepted. The row compares all cells against the sample in parallel
//   and each cell takes its left neighbour's value when the sample lands
//   ahead of it.
//   Drain: the first result is offered the cycle after the closing item
//   is accepted; results then leave the head of the row one per cycle
//   while i_out_ready is high.
//   Input is held off (o_in_ready low) while a set drains; it reopens the
//   cycle after the final result is taken.
//   Stall: with i_out_ready low the row simply holds, the head result stays
//   on the output unchanged.
//   Reset: synchronous, active low; empties every cell and the fill count,
//   and returns the block to filling. No clearing pass is needed.
module merge_sort_integers (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mgs_pkg::t_value i_sample,
    input  logic            i_is_final,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mgs_pkg::t_value o_sorted_value,
    output logic            o_final_out
);
    import mgs_pkg::*;

    // Control state: fill count of the open set, drain flag
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_drain;
    logic             n_drain;

    // Row wiring, one entry per cell at a fixed place
    t_value     w_value [SIZE];
    logic       w_valid [SIZE];
    logic       w_gt    [SIZE];
    t_cell_ctrl w_ctrl;

    logic w_in_take;
    logic w_out_take;
    logic w_close;

    assign o_in_ready  = !r_drain;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign o_out_valid = r_drain;
    assign w_out_take  = o_out_valid && i_out_ready;

    // head of the row is the smallest remaining value; last when cell 1 is empty
    assign o_sorted_value = w_value[0];
    assign o_final_out    = !w_valid[1];

    // close on the marked item or on the item that fills the row
    assign w_close = i_is_final || (r_count == CNT_W'(SIZE - 1));

    // insert while filling, shift while draining
    assign w_ctrl = {w_in_take, w_out_take};

    always_comb begin
        n_count = r_count;
        n_drain = r_drain;
        if (w_in_take) begin
            if (w_close) begin
                n_count = '0;
                n_drain = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
        // drop out of drain once the final item has gone
        if (w_out_take && o_final_out) begin
            n_drain = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drain <= 1'b0;
        end else begin
            r_count <= n_count;
            r_drain <= n_drain;
        end
    end

    // Ordered row: cell 0 holds the smallest value, empty cells trail
    for (genvar g = 0; g < SIZE; g++) begin : g_cell
        t_value w_lv;
        logic   w_lvd;
        logic   w_lgt;
        t_value w_rv;
        logic   w_rvd;

        if (g == 0) begin : g_head
            assign w_lv  = '0;
            assign w_lvd = 1'b0;
            assign w_lgt = 1'b0;
        end else begin : g_body
            assign w_lv  = w_value[g-1];
            assign w_lvd = w_valid[g-1];
            assign w_lgt = w_gt[g-1];
        end

        if (g == SIZE - 1) begin : g_tail
            assign w_rv  = '0;
            assign w_rvd = 1'b0;
        end else begin : g_mid
            assign w_rv  = w_value[g+1];
            assign w_rvd = w_valid[g+1];
        end

        mgs_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_sample      (i_sample),
            .i_left_value  (w_lv),
            .i_left_valid  (w_lvd),
            .i_left_gt     (w_lgt),
            .i_right_value (w_rv),
            .i_right_valid (w_rvd),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Fill count stays clear for the whole drain
    a_count_clear_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_count == '0))
        else $error("fill count not clear while draining");

    // While draining the head cell always holds a value
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> w_valid[0])
        else $error("draining with an empty head cell");

    // Results leave in non-decreasing order within a set
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && !o_final_out) |=>
            (o_out_valid && ($past(o_sorted_value) <= o_sorted_value)))
        else $error("results out of order");

    // Taking the final result empties the row and reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && o_final_out) |=> (o_in_ready && !w_valid[0]))
        else $error("row not empty after the final result");

endmodule

// ----- verif/tb_merge_sort_integers.sv -----
// Self-checking testbench for merge_sort_integers: random sets, stalls, sorted-order check.
`timescale 1ns / 1ps
module tb_merge_sort_integers;
    import mgs_pkg::*;

    // Chance in a hundred that either side idles in a given cycle
    localparam int IDLE_PCT     = 19;
    // Cycles with no accepted item on either side before the run is abandoned
    localparam int QUIET_LIMIT  = 2000;
    // Wait after the last result, long enough for a full set to drain, plus margin
    localparam int DRAIN_CYCLES = 2 * SIZE + 8;
    // Target count of random input items
    localparam int RANDOM_ITEMS = 150;

    // One input item waiting to be offered to the sorter
    typedef struct {
        t_value sample;
        logic   last;
    } t_sample_item;

    // One result that the sorter must return, in order
    typedef struct {
        t_value value;
        logic   last;
    } t_sorted_result;

    logic   i_clk          = 1'b0;
    logic   i_rst_n        = 1'b0;
    logic   i_in_valid     = 1'b0;
    logic   o_in_ready;
    t_value i_sample       = '0;
    logic   i_is_final     = 1'b0;
    logic   o_out_valid;
    logic   i_out_ready    = 1'b0;
    t_value o_sorted_value;
    logic   o_final_out;

    t_sample_item   pending_items[$];
    t_value         open_set[$];
    t_sorted_result sorted_due[$];

    int unsigned items_sent    = 0;
    int unsigned results_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles  = 0;

    merge_sort_integers u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_is_final     (i_is_final),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_final_out    (o_final_out)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Print one line per fault and count it
    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Add one accepted sample to the open set. When the set closes, by its
    // final mark or by filling the store, sort a copy in ascending signed
    // order (stable, so duplicates keep arrival order) and queue the results.
    task automatic absorb_sample(input t_value sample, input logic last);
        t_value         ordered[$];
        t_value         pick;
        int             j;
        t_sorted_result res;
        open_set.insert(open_set.size(), sample);
        if (last || open_set.size() >= SIZE) begin
            ordered = open_set;
            for (int i = 1; i < ordered.size(); i++) begin
                pick = ordered[i];
                j    = i - 1;
                while (j >= 0 && ordered[j] > pick) begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = pick;
            end
            foreach (ordered[k]) begin
                res.value = ordered[k];
                res.last  = (k == ordered.size() - 1);
                sorted_due.insert(sorted_due.size(), res);
            end
            open_set.delete();
        end
    endtask

    // Queue one input item
    task automatic queue_sample(input t_value sample, input logic last);
        t_sample_item entry;
        entry.sample = sample;
        entry.last   = last;
        pending_items.insert(pending_items.size(), entry);
    endtask

    // Draw a value: mostly full-range, with clusters of small values to force
    // duplicates and a share of values at or near the signed extremes.
    function automatic t_value random_sample();
        case ($urandom_range(0, 5))
            0:       return t_value'($urandom_range(0, 7)) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return t_value'(32'h8000_0000) + t_value'($urandom_range(0, 2));
                    1:       return t_value'(32'h7fff_ffff) - t_value'($urandom_range(0, 2));
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return t_value'($urandom);
        endcase
    endfunction

    // Fill the stimulus queue, run, then wait for the sorter to drain
    initial begin
        int unsigned random_count;
        int unsigned set_len;
        logic        tail_final;

        // Single value: one result, flagged final
        queue_sample(t_value'(32'h7fff_ffff), 1'b1);

        // Signed extremes, zero and minus one in one set
        queue_sample(t_value'(32'h7fff_ffff), 1'b0);
        queue_sample(t_value'(32'h8000_0000), 1'b0);
        queue_sample('0, 1'b0);
        queue_sample('1, 1'b1);

        // Duplicates in one set
        queue_sample(t_value'(5), 1'b0);
        queue_sample(t_value'(-5), 1'b0);
        queue_sample(t_value'(5), 1'b1);

        // Full store: the sixteenth value closes the set with no final mark
        for (int k = 0; k < SIZE; k++)
            queue_sample((k % 2) ? -t_value'(k * 1000) : t_value'(k * 123457), 1'b0);

        // Random sets, mostly short and well formed; some fill the store,
        // some run past it so the store closes mid-sequence
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            tail_final = 1'b1;
            case ($urandom_range(0, 9))
                7: begin
                    set_len    = SIZE;
                    tail_final = 1'($urandom_range(0, 1));
                end
                8:       set_len = $urandom_range(SIZE + 1, SIZE + 8);
                9:       set_len = $urandom_range(9, SIZE - 1);
                default: set_len = $urandom_range(1, 8);
            endcase
            for (int k = 0; k < set_len; k++)
                queue_sample(random_sample(), (k == set_len - 1) ? tail_final : 1'b0);
            random_count += set_len;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every item is in and every result is out
        @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || sorted_due.size() != 0)
            @(posedge i_clk);
        // Allow time for any stray result to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Input driver: offer the next queued item when the channel is free.
    // Idle at random, except in a stretch of items where it never idles.
    always @(posedge i_clk) begin
        t_sample_item head_item;
        logic         steady;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                absorb_sample(i_sample, i_is_final);
                items_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                steady = (items_sent >= 60 && items_sent < 120);
                if (pending_items.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    head_item  = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample   <= head_item.sample;
                    i_is_final <= head_item.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: stall at random, except in a stretch of results where
    // ready stays high; check each taken result against the oldest one due.
    always @(posedge i_clk) begin
        t_sorted_result due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sorted_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d final %0b",
                                          o_sorted_value, o_final_out));
            end else begin
                due = sorted_due.pop_front();
                if (o_sorted_value !== due.value)
                    report_mismatch($sformatf("result %0d: value %0d, want %0d",
                                              results_taken, o_sorted_value, due.value));
                if (o_final_out !== due.last)
                    report_mismatch($sformatf("result %0d: final flag %0b, want %0b",
                                              results_taken, o_final_out, due.last));
            end
            results_taken++;
        end
        i_out_ready <= (results_taken >= 50 && results_taken < 130) ||
                       ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: abandon the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR at %0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- files.f -----
hw/rtl/mgs_pkg.sv
hw/rtl/mgs_cell.sv
hw/rtl/merge_sort_integers.sv
verif/tb_merge_sort_integers.sv
